// File: sv/spim_pkg.sv
// Shared constants and types for the mode 0 SPI master.
`timescale 1ns / 1ps
`default_nettype none

package spim_pkg;

    localparam int WORD_BITS = 32;
    localparam int LEN_W     = 6;
    localparam int IDX_W     = $clog2(WORD_BITS);
    localparam int RX_W      = 8;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_XFER  = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    localparam logic [1:0] PH_DRIVE  = 2'd0;
    localparam logic [1:0] PH_RISE   = 2'd1;
    localparam logic [1:0] PH_SAMPLE = 2'd2;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(WORD_BITS);

    typedef struct packed {
        logic            sclk;
        logic            mosi;
        logic            csel;
        logic            busy;
        logic            done;
        logic [RX_W-1:0] rx_data;
    } spim_res_t;

endpackage

`default_nettype wire

// File: sv/spim_core.sv
// Command decode and bit sequencing state of the SPI master.
`timescale 1ns / 1ps
`default_nettype none

module spim_core
    import spim_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic [1:0]           cmd,
    input  wire logic [WORD_BITS-1:0] tx_data,
    input  wire logic [LEN_W-1:0]     bit_len,
    input  wire logic                 miso,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_three_wire,
    output spim_res_t                 res
);

    logic [WORD_BITS-1:0] tx_shift_reg, tx_shift_next;
    logic [RX_W-1:0]      rx_shift_reg, rx_shift_next;
    logic [LEN_W-1:0]     bits_left_reg, bits_left_next;
    logic [1:0]           phase_reg, phase_next;
    logic                 active_reg, active_next;
    logic                 sclk_reg, sclk_next;
    logic                 mosi_reg, mosi_next;
    logic                 csel_reg, csel_next;
    logic                 three_wire_reg;
    logic                 done;
    logic [RX_W-1:0]      rx_out;
    logic [IDX_W-1:0]     bit_idx;
    logic [LEN_W-1:0]     len_sat;
    logic                 rx_bit;

    // While active, bits_left is between 1 and WORD_BITS, so the index fits.
    assign bit_idx = IDX_W'(bits_left_reg - LEN_W'(1));
    assign len_sat = (bit_len > LEN_MAX) ? LEN_MAX : bit_len;
    assign rx_bit  = three_wire_reg ? 1'b0 : miso;

    always_comb
    begin
        tx_shift_next  = tx_shift_reg;
        rx_shift_next  = rx_shift_reg;
        bits_left_next = bits_left_reg;
        phase_next     = phase_reg;
        active_next    = active_reg;
        sclk_next      = sclk_reg;
        mosi_next      = mosi_reg;
        csel_next      = csel_reg;
        done           = 1'b0;
        rx_out         = '0;
        if (active_reg)
        begin
            // Only ticks move a transfer along; other commands are dropped.
            if (cmd == CMD_TICK)
            begin
                unique case (phase_reg)
                    PH_DRIVE:
                    begin
                        mosi_next  = tx_shift_reg[bit_idx];
                        phase_next = PH_RISE;
                    end
                    PH_RISE:
                    begin
                        sclk_next  = 1'b1;
                        phase_next = PH_SAMPLE;
                    end
                    default:
                    begin
                        rx_shift_next  = {rx_shift_reg[RX_W-2:0], rx_bit};
                        sclk_next      = 1'b0;
                        bits_left_next = bits_left_reg - LEN_W'(1);
                        phase_next     = PH_DRIVE;
                        if (bits_left_reg == LEN_W'(1))
                        begin
                            active_next = 1'b0;
                            done        = 1'b1;
                            rx_out      = rx_shift_next;
                        end
                    end
                endcase
            end
        end
        else
        begin
            unique case (cmd)
                CMD_START:
                begin
                    sclk_next = 1'b0;
                    mosi_next = 1'b0;
                    csel_next = 1'b0;
                end
                CMD_XFER:
                begin
                    sclk_next      = 1'b0;
                    tx_shift_next  = tx_data;
                    rx_shift_next  = '0;
                    bits_left_next = len_sat;
                    phase_next     = PH_DRIVE;
                    if (len_sat == '0)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        active_next = 1'b1;
                    end
                end
                CMD_STOP:
                begin
                    mosi_next = 1'b0;
                    csel_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_shift_reg  <= '0;
            rx_shift_reg  <= '0;
            bits_left_reg <= '0;
            phase_reg     <= PH_DRIVE;
            active_reg    <= 1'b0;
            sclk_reg      <= 1'b0;
            mosi_reg      <= 1'b0;
            csel_reg      <= 1'b1;
        end
        else if (step)
        begin
            tx_shift_reg  <= tx_shift_next;
            rx_shift_reg  <= rx_shift_next;
            bits_left_reg <= bits_left_next;
            phase_reg     <= phase_next;
            active_reg    <= active_next;
            sclk_reg      <= sclk_next;
            mosi_reg      <= mosi_next;
            csel_reg      <= csel_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            three_wire_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            three_wire_reg <= cfg_three_wire;
        end
    end

    assign res.sclk    = sclk_next;
    assign res.mosi    = mosi_next;
    assign res.csel    = csel_next;
    assign res.busy    = active_next;
    assign res.done    = done;
    assign res.rx_data = rx_out;

    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DRIVE || phase_reg == PH_RISE || phase_reg == PH_SAMPLE))
        else $error("phase register holds an unused code");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (bits_left_reg != '0 && bits_left_reg <= LEN_MAX))
        else $error("active transfer with bit count out of range");

    a_sclk_high: assert property (@(posedge clk) disable iff (!rst_n)
        sclk_reg |-> (active_reg && phase_reg == PH_SAMPLE))
        else $error("SCLK high outside the sample phase");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.done) |=> !active_reg)
        else $error("transfer still active after completion");

endmodule

`default_nettype wire

// File: sv/spim_obuf.sv
// Two-entry result buffer: an output register with a skid entry behind it.
`timescale 1ns / 1ps
`default_nettype none

module spim_obuf
    import spim_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire spim_res_t push_data,
    output logic           can_push,
    output logic           head_valid,
    input  wire logic      pop,
    output spim_res_t      head_data
);

    logic      a_valid_reg, a_valid_next;
    logic      b_valid_reg, b_valid_next;
    spim_res_t a_reg, a_next;
    spim_res_t b_reg, b_next;
    logic      take;

    assign take       = a_valid_reg && pop;
    assign can_push   = !b_valid_reg;
    assign head_valid = a_valid_reg;
    assign head_data  = a_reg;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        if (take)
        begin
            if (b_valid_reg)
            begin
                a_next       = b_reg;
                b_next       = push_data;
                b_valid_next = push;
            end
            else
            begin
                a_next       = push_data;
                a_valid_next = push;
            end
        end
        else if (push)
        begin
            if (!a_valid_reg)
            begin
                a_next       = push_data;
                a_valid_next = 1'b1;
            end
            else
            begin
                b_next       = push_data;
                b_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> a_valid_reg)
        else $error("skid entry holds a result while the head is empty");

endmodule

`default_nettype wire

// File: sv/spi_master_mode0_variable_length.sv
// Top level of the tick-driven mode 0 SPI master.
//
//  channel | signals                                   | dir | request moves
//  --------+-------------------------------------------+-----+------------------------------
//  in      | in_valid in_ready cmd tx_data bit_len miso | in  | one command or delay tick
//  out     | out_valid out_ready sclk mosi csel busy_res | out | pin levels and status
//          | done_res rx_data                          |     | after that command
//  cfg     | cfg_valid cfg_ready cfg_data              | in  | three-wire mode bit
//
// One request is accepted per cycle while in_ready is high; its result is registered.
// The command state is updated in the accept cycle by one level of logic. A two-entry
// output buffer keeps input accepts going while out_ready is low; in_ready falls only
// when both entries are full. Reset leaves chip select high, SCLK and MOSI low, no
// transfer in progress and three-wire mode off. Config is always ready.
`timescale 1ns / 1ps
`default_nettype none

module spi_master_mode0_variable_length
    import spim_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           cmd,
    input  wire logic [WORD_BITS-1:0] tx_data,
    input  wire logic [LEN_W-1:0]     bit_len,
    input  wire logic                 miso,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      sclk,
    output logic                      mosi,
    output logic                      csel,
    output logic                      busy_res,
    output logic                      done_res,
    output logic [RX_W-1:0]           rx_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_data
);

    spim_res_t res;
    spim_res_t head;
    logic      step;

    assign cfg_ready = 1'b1;
    assign step      = in_valid && in_ready;

    spim_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .cmd            (cmd),
        .tx_data        (tx_data),
        .bit_len        (bit_len),
        .miso           (miso),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_three_wire (cfg_data),
        .res            (res)
    );

    spim_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (step),
        .push_data  (res),
        .can_push   (in_ready),
        .head_valid (out_valid),
        .pop        (out_ready),
        .head_data  (head)
    );

    assign sclk     = head.sclk;
    assign mosi     = head.mosi;
    assign csel     = head.csel;
    assign busy_res = head.busy;
    assign done_res = head.done;
    assign rx_data  = head.rx_data;

endmodule

`default_nettype wire

// File: dv/spi_master_mode0_variable_length_tb.sv
// Self-checking testbench for the tick-driven mode 0 SPI master.
`timescale 1ns / 1ps

module spi_master_mode0_variable_length_tb
    import spim_pkg::*;
();

    localparam int N_ROWS    = 21;
    localparam int HOLD_LONG = 150;

    typedef struct packed {
        logic [1:0]           op;
        logic [WORD_BITS-1:0] word;
        logic [LEN_W-1:0]     len;
        logic                 miso_in;
        bit                   typed;
        spim_res_t            want;
    } spi_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           cmd;
    logic [WORD_BITS-1:0] tx_data;
    logic [LEN_W-1:0]     bit_len;
    logic                 miso;
    logic                 out_valid;
    logic                 out_ready;
    logic                 sclk;
    logic                 mosi;
    logic                 csel;
    logic                 busy_res;
    logic                 done_res;
    logic [RX_W-1:0]      rx_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_data;

    // Shadow of the master's state, kept in step with every accepted request.
    logic [WORD_BITS-1:0] sh_tx     = '0;
    logic [RX_W-1:0]      sh_rx     = '0;
    logic [LEN_W-1:0]     sh_bits   = '0;
    logic [1:0]           sh_phase  = PH_DRIVE;
    logic                 sh_active = 1'b0;
    logic                 sh_sclk   = 1'b0;
    logic                 sh_mosi   = 1'b0;
    logic                 sh_csel   = 1'b1;
    logic                 sh_three  = 1'b0;

    spim_res_t pending_levels[$];
    int        err_count    = 0;
    bit        tx_idle      = 1'b1;
    bit        rx_idle      = 1'b1;
    int        hold_request = 0;
    int        hold_left    = 0;
    int        stall_left   = 0;
    spim_res_t got;
    spim_res_t want;

    // Pin order in each expectation: sclk, mosi, csel, busy, done, rx_data.
    spi_row_t dir_rows [N_ROWS] = '{
        '{CMD_TICK,  32'h0000_0000, 6'd0,  1'b1, 1'b1, {1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00}},
        '{CMD_STOP,  32'hFFFF_FFFF, 6'd63, 1'b0, 1'b1, {1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00}},
        '{CMD_START, 32'h0000_0000, 6'd0,  1'b0, 1'b1, {1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00}},
        '{CMD_XFER,  32'hFFFF_FFFF, 6'd0,  1'b1, 1'b1, {1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00}},
        '{CMD_XFER,  32'hFFFF_FFFE, 6'd2,  1'b0, 1'b1, {1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00}},
        '{CMD_START, 32'h0000_0000, 6'd0,  1'b0, 1'b0, '0},
        '{CMD_TICK,  32'h0000_0000, 6'd0,  1'b1, 1'b0, '0},
        '{CMD_XFER,  32'h0000_0000, 6'd5,  1'b0, 1'b0, '0},
        '{CMD_TICK,  32'h0000_0000, 6'd0,  1'b0, 1'b0, '0},
        '{CMD_STOP,  32'h0000_0000, 6'd0,  1'b0, 1'b0, '0},
        '{CMD_TICK,  32'h0000_0000, 6'd0,  1'b1, 1'b0, '0},
        '{CMD_TICK,  32'h0000_0000, 6'd0,  1'b0, 1'b0, '0},
        '{CMD_TICK,  32'h0000_0000, 6'd0,  1'b1, 1'b0, '0},
        '{CMD_TICK,  32'h0000_0000, 6'd0,  1'b0, 1'b0, '0},
        '{CMD_STOP,  32'h0000_0000, 6'd0,  1'b0, 1'b0, '0},
        '{CMD_XFER,  32'h0000_0000, 6'd1,  1'b0, 1'b1, {1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00}},
        '{CMD_TICK,  32'h0000_0000, 6'd0,  1'b1, 1'b0, '0},
        '{CMD_TICK,  32'h0000_0000, 6'd0,  1'b1, 1'b0, '0},
        '{CMD_TICK,  32'h0000_0000, 6'd0,  1'b1, 1'b0, '0},
        '{CMD_START, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b1, {1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00}},
        '{CMD_TICK,  32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, '0}
    };

    spi_master_mode0_variable_length i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .tx_data   (tx_data),
        .bit_len   (bit_len),
        .miso      (miso),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sclk      (sclk),
        .mosi      (mosi),
        .csel      (csel),
        .busy_res  (busy_res),
        .done_res  (done_res),
        .rx_data   (rx_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= 100)
            $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // Applies one request to the shadow state and returns the pin levels it leaves.
    function automatic spim_res_t advance_spi(input logic [1:0] op,
                                              input logic [WORD_BITS-1:0] word,
                                              input logic [LEN_W-1:0] len,
                                              input logic miso_in);
        spim_res_t r;
        logic [LEN_W-1:0] n;
        r = '0;
        n = len;
        if (sh_active)
        begin
            // While a transfer runs, only ticks have any effect.
            if (op == CMD_TICK)
            begin
                case (sh_phase)
                    PH_DRIVE:
                    begin
                        sh_mosi  = sh_tx[IDX_W'(sh_bits - 6'd1)];
                        sh_phase = PH_RISE;
                    end
                    PH_RISE:
                    begin
                        sh_sclk  = 1'b1;
                        sh_phase = PH_SAMPLE;
                    end
                    default:
                    begin
                        sh_rx    = {sh_rx[RX_W-2:0], sh_three ? 1'b0 : miso_in};
                        sh_sclk  = 1'b0;
                        sh_bits  = sh_bits - 6'd1;
                        sh_phase = PH_DRIVE;
                        if (sh_bits == '0)
                        begin
                            sh_active = 1'b0;
                            r.done    = 1'b1;
                            r.rx_data = sh_rx;
                        end
                    end
                endcase
            end
        end
        else if (op == CMD_START)
        begin
            sh_sclk = 1'b0;
            sh_mosi = 1'b0;
            sh_csel = 1'b0;
        end
        else if (op == CMD_XFER)
        begin
            if (n > LEN_MAX)
                n = LEN_MAX;
            sh_sclk  = 1'b0;
            sh_tx    = word;
            sh_rx    = '0;
            sh_bits  = n;
            sh_phase = PH_DRIVE;
            if (n == '0)
                r.done = 1'b1;
            else
                sh_active = 1'b1;
        end
        else if (op == CMD_STOP)
        begin
            sh_mosi = 1'b0;
            sh_csel = 1'b1;
        end
        r.sclk = sh_sclk;
        r.mosi = sh_mosi;
        r.csel = sh_csel;
        r.busy = sh_active;
        return r;
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [WORD_BITS-1:0] word,
                             input logic [LEN_W-1:0] len, input logic miso_in,
                             input bit typed = 1'b0, input spim_res_t typed_want = '0);
        spim_res_t predicted;
        int gap;
        if (tx_idle && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        tx_data  <= word;
        bit_len  <= len;
        miso     <= miso_in;
        do @(posedge clk); while (!in_ready);
        predicted = advance_spi(op, word, len, miso_in);
        pending_levels.push_back(typed ? typed_want : predicted);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_three_wire(input bit v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sh_three = v;
    endtask

    // Mostly whole frames with random content, plus loose commands as noise.
    task automatic run_frames(input int n_items);
        int sent;
        int len_eff;
        int pick;
        logic [LEN_W-1:0] len;
        logic [WORD_BITS-1:0] word;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    send_item(CMD_START, $urandom, 6'($urandom), 1'($urandom));
                    sent++;
                end
                pick = $urandom_range(0, 31);
                if (pick == 0)
                    len = '0;
                else if (pick < 3)
                    len = 6'($urandom_range(33, 63));
                else if (pick < 7)
                    len = 6'($urandom_range(13, 32));
                else
                    len = 6'($urandom_range(1, 12));
                pick = $urandom_range(0, 15);
                word = (pick == 0) ? '0 : (pick == 1) ? '1 : WORD_BITS'($urandom);
                send_item(CMD_XFER, word, len, 1'($urandom));
                sent++;
                len_eff = (len > LEN_MAX) ? WORD_BITS : int'(len);
                repeat (3 * len_eff)
                begin
                    // A command that should be ignored mid-transfer; not counted.
                    if ($urandom_range(0, 19) == 0)
                        send_item(2'($urandom_range(1, 3)), $urandom, 6'($urandom),
                                  1'($urandom));
                    send_item(CMD_TICK, $urandom, 6'($urandom), 1'($urandom));
                    sent++;
                end
                if ($urandom_range(0, 3) != 0)
                begin
                    send_item(CMD_STOP, $urandom, 6'($urandom), 1'($urandom));
                    sent++;
                end
            end
            else
            begin
                send_item(2'($urandom), $urandom, 6'($urandom), 1'($urandom));
                sent++;
            end
        end
    endtask

    // Result side: checks each accepted result and stalls in random bursts.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got = {sclk, mosi, csel, busy_res, done_res, rx_data};
                if (pending_levels.size() == 0)
                begin
                    flag_error($sformatf("result %h with nothing pending", got));
                end
                else
                begin
                    want = pending_levels.pop_front();
                    if (got.sclk !== want.sclk)
                        flag_error($sformatf("sclk %b, expected %b", got.sclk, want.sclk));
                    if (got.mosi !== want.mosi)
                        flag_error($sformatf("mosi %b, expected %b", got.mosi, want.mosi));
                    if (got.csel !== want.csel)
                        flag_error($sformatf("csel %b, expected %b", got.csel, want.csel));
                    if (got.busy !== want.busy)
                        flag_error($sformatf("busy_res %b, expected %b", got.busy, want.busy));
                    if (got.done !== want.done)
                        flag_error($sformatf("done_res %b, expected %b", got.done, want.done));
                    if (got.rx_data !== want.rx_data)
                        flag_error($sformatf("rx_data %h, expected %h",
                                             got.rx_data, want.rx_data));
                end
            end
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (rx_idle && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 10);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        cmd       = CMD_TICK;
        tx_data   = '0;
        bit_len   = '0;
        miso      = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        write_three_wire(1'b0);
        for (int i = 0; i < N_ROWS; i++)
            send_item(dir_rows[i].op, dir_rows[i].word, dir_rows[i].len,
                      dir_rows[i].miso_in, dir_rows[i].typed, dir_rows[i].want);

        // Long hold on the result side while requests keep coming, so the buffer fills.
        write_three_wire(1'b1);
        tx_idle      = 1'b0;
        hold_request = HOLD_LONG;
        run_frames(100);
        tx_idle = 1'b1;
        run_frames(200);

        write_three_wire(1'b0);
        run_frames(300);

        write_three_wire(1'b1);
        run_frames(250);

        write_three_wire(1'b0);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        run_frames(300);

        drain_results();
        repeat (4) @(posedge clk);
        if (err_count == 0)
            $display("** spi_master_mode0_variable_length: PASSED **");
        else
            $display("** spi_master_mode0_variable_length: FAILED **");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("Timeout with %0d results pending", pending_levels.size());
        $display("** spi_master_mode0_variable_length: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
sv/spim_pkg.sv
sv/spim_core.sv
sv/spim_obuf.sv
sv/spi_master_mode0_variable_length.sv
dv/spi_master_mode0_variable_length_tb.sv
